/* rtl/rkfs_pkg.sv */
// Shared types, constants and command codes of the keyframe fade sequencer.
package rkfs_pkg;

	localparam int MaxSteps = 16;
	localparam int StepW = $clog2(MaxSteps);
	localparam int CntW = $clog2(MaxSteps + 1);
	localparam int FrameW = 15;
	localparam int AccW = 18;
	localparam int DeltaW = 17;
	localparam int DivW = 17;
	localparam int QueueDepth = 4;
	localparam int QPtrW = $clog2(QueueDepth);

	typedef enum logic [2:0] {
		CMD_TICK = 3'd0,
		CMD_COLOUR = 3'd1,
		CMD_FRAMES = 3'd2,
		CMD_START = 3'd3,
		CMD_STOP = 3'd4,
		CMD_PAUSE = 3'd5,
		CMD_RESUME = 3'd6,
		CMD_NONE = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		REG_NUM_STEPS = 2'd0,
		REG_REPEAT = 2'd1,
		REG_LAMP = 2'd2
	} reg_t;

	typedef struct packed {
		cmd_t cmd;
		logic [StepW-1:0] step;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [FrameW-1:0] frames;
		logic ramp;
	} word_t;

	localparam int WordW = $bits(word_t);

endpackage

/* rtl/rgb_keyframe_fade_sequencer_core.sv */
// Top level of the keyframe RGB fade sequencer.
// Command words enter through push/full and are queued; results leave
// through empty/pop, one word per emitting tick, holding lamp number,
// the integer bits [15:8] of the 10.8 colour accumulators and a finished flag.
// Configuration (num_steps, repeat_mode, lamp_select) is written through
// cfg_valid/cfg_ready/cfg_index/cfg_data and is always ready.
// A tick passes from the queue head through the IDLE and TICK states to
// the result register. A colour or frames write recomputes up to two
// deltas, each three 17-step divisions, and occupies the back end until
// they are written. Start, stop, pause and resume act in IDLE as they
// are taken. The front queue holds four words, so pushes continue while
// the back end divides.
// Reset clears playback state, sets the table to black with frame count
// one and empties the queue and result register. While the receiver
// does not pop, a waiting result stays; a following tick waits at the
// head of the queue and the queue fills until full rises.
module rgb_keyframe_fade_sequencer_core import rkfs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic [2:0] cmd,
	input logic [3:0] step_index,
	input logic [7:0] red_in,
	input logic [7:0] green_in,
	input logic [7:0] blue_in,
	input logic [14:0] frame_count,
	input logic interpolate,
	output logic empty,
	input logic pop,
	output logic [7:0] lamp_index,
	output logic [7:0] red_out,
	output logic [7:0] green_out,
	output logic [7:0] blue_out,
	output logic finished,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [7:0] cfg_data
);
	word_t in_word, q_word;
	logic q_valid, q_take;
	logic [4:0] num_steps_q;
	logic repeat_q;
	logic [7:0] lamp_q;

	assign cfg_ready = 1'b1;
	assign in_word = '{cmd: cmd_t'(cmd), step: step_index, red: red_in,
		green: green_in, blue: blue_in, frames: frame_count, ramp: interpolate};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_steps_q <= '0;
			repeat_q <= 1'b0;
			lamp_q <= '0;
		end else if (cfg_valid) begin
			unique case (reg_t'(cfg_index))
				REG_NUM_STEPS: num_steps_q <= cfg_data[4:0];
				REG_REPEAT: repeat_q <= cfg_data[0];
				REG_LAMP: lamp_q <= cfg_data;
				default: ;
			endcase
		end
	end

	rkfs_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_word(in_word),
		.q_valid(q_valid), .q_take(q_take), .q_word(q_word)
	);

	rkfs_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_take(q_take),
		.q_word(q_word), .num_steps(num_steps_q), .repeat_mode(repeat_q),
		.lamp_select(lamp_q), .empty(empty), .pop(pop), .lamp_index(lamp_index),
		.red_out(red_out), .green_out(green_out), .blue_out(blue_out),
		.finished(finished)
	);
endmodule

/* rtl/rkfs_ram.sv */
// Generic simple dual-port RAM (one write port, one read port) with registered read.
module rkfs_ram #(
	parameter int Width = 8,
	parameter int Depth = 4
) (
	input logic clk,
	input logic we,
	input logic [$clog2(Depth)-1:0] waddr,
	input logic [Width-1:0] wdata,
	input logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem [Depth];
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* rtl/rkfs_front.sv */
// Front end: accepts command words, drops useless ones and queues the rest.
module rkfs_front import rkfs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input word_t in_word,
	output logic q_valid,
	input logic q_take,
	output word_t q_word
);
	word_t qmem [QueueDepth];
	logic [QPtrW-1:0] wp_q, rp_q;
	logic [QPtrW:0] cnt_q;
	logic acc, keep;

	assign full = (cnt_q == (QPtrW+1)'(QueueDepth));
	assign acc = push && !full;
	assign keep = acc && (in_word.cmd != CMD_NONE);
	assign q_valid = (cnt_q != '0);
	assign q_word = qmem[rp_q];

	always_ff @(posedge clk) begin
		if (keep) begin
			qmem[wp_q] <= in_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (keep) begin
				wp_q <= wp_q + 1'b1;
			end
			if (q_take && q_valid) begin
				rp_q <= rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (QPtrW+1)'(keep) - (QPtrW+1)'(q_take && q_valid);
		end
	end
endmodule

/* rtl/rkfs_div.sv */
// Iterative signed divider: 17-bit dividend by 15-bit positive divisor, truncating.
module rkfs_div import rkfs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic signed [DivW-1:0] dividend,
	input logic [FrameW-1:0] divisor,
	output logic done,
	output logic signed [DeltaW-1:0] quotient
);
	logic [DivW-1:0] mag_q, quo_q;
	logic [FrameW:0] rem_q;
	logic [FrameW-1:0] dsr_q;
	logic neg_q;
	logic [$clog2(DivW+1)-1:0] cnt_q;
	logic [FrameW+1:0] trial;
	logic [FrameW:0] shifted;
	logic busy;

	assign shifted = {rem_q[FrameW-1:0], mag_q[DivW-1]};
	assign trial = {1'b0, shifted} - {2'b00, dsr_q};
	assign busy = (cnt_q != '0);
	assign quotient = neg_q ? -$signed(quo_q) : $signed(quo_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				cnt_q <= ($clog2(DivW+1))'(DivW);
			end else if (busy) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 1) begin
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[DivW-1];
			mag_q <= dividend[DivW-1] ? DivW'(-dividend) : DivW'(dividend);
			rem_q <= '0;
			quo_q <= '0;
			dsr_q <= divisor;
		end else if (busy) begin
			mag_q <= {mag_q[DivW-2:0], 1'b0};
			if (!trial[FrameW+1]) begin
				rem_q <= trial[FrameW:0];
				quo_q <= {quo_q[DivW-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[DivW-2:0], 1'b0};
			end
		end
	end
endmodule

/* rtl/rkfs_back.sv */
// Back end: keyframe tables, delta recompute sequencer and playback state.
module rkfs_back import rkfs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	output logic q_take,
	input word_t q_word,
	input logic [4:0] num_steps,
	input logic repeat_mode,
	input logic [7:0] lamp_select,
	output logic empty,
	input logic pop,
	output logic [7:0] lamp_index,
	output logic [7:0] red_out,
	output logic [7:0] green_out,
	output logic [7:0] blue_out,
	output logic finished
);
	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_TICK = 7'b0000010,
		ST_CALC = 7'b0000100,
		ST_RD = 7'b0001000,
		ST_DIV = 7'b0010000,
		ST_WAIT = 7'b0100000,
		ST_WR = 7'b1000000
	} state_t;

	state_t st_q;
	logic [23:0] colour_q [MaxSteps];
	logic [FrameW-1:0] frames_q [MaxSteps];
	logic [MaxSteps-1:0] ramp_q;
	logic [MaxSteps-1:0] dvalid_q;
	logic [3*DeltaW-1:0] drd;
	logic [3*DeltaW-1:0] dwr_q;
	logic [1:0] run_q;
	logic [StepW-1:0] step_q;
	logic [FrameW-1:0] fpos_q;
	logic [AccW-1:0] acc_q [3];
	logic [CntW-1:0] n;
	logic [StepW-1:0] s_rd;

	// Pending delta jobs: previous step and own step.
	logic job_prev_q, job_own_q;
	logic [StepW-1:0] from_q, to_q, widx_q;
	logic [1:0] ch_q;
	logic dstart, ddone;
	logic signed [DeltaW-1:0] dq;
	logic signed [DivW-1:0] diff;
	logic [7:0] ca, cb;

	logic ovalid_q;
	logic [7:0] o_lamp_q, o_r_q, o_g_q, o_b_q;
	logic o_fin_q;

	assign n = (num_steps > 5'(MaxSteps)) ? CntW'(MaxSteps) : CntW'(num_steps);
	assign empty = !ovalid_q;
	assign lamp_index = o_lamp_q;
	assign red_out = o_r_q;
	assign green_out = o_g_q;
	assign blue_out = o_b_q;
	assign finished = o_fin_q;
	assign s_rd = step_q;

	rkfs_ram #(.Width(3*DeltaW), .Depth(MaxSteps)) u_delta (
		.clk(clk), .we(st_q == ST_WR), .waddr(widx_q), .wdata(dwr_q),
		.raddr(s_rd), .rdata(drd)
	);

	always_comb begin
		unique case (ch_q)
			2'd0: begin ca = colour_q[to_q][23:16]; cb = colour_q[from_q][23:16]; end
			2'd1: begin ca = colour_q[to_q][15:8]; cb = colour_q[from_q][15:8]; end
			default: begin ca = colour_q[to_q][7:0]; cb = colour_q[from_q][7:0]; end
		endcase
		diff = $signed({1'b0, ca, 8'h00}) - $signed({1'b0, cb, 8'h00});
	end
	assign dstart = (st_q == ST_DIV);

	rkfs_div u_div (
		.clk(clk), .arst_n(arst_n), .start(dstart), .dividend(diff),
		.divisor(frames_q[from_q]), .done(ddone), .quotient(dq)
	);

	// A queued word is taken in IDLE unless a tick would find the output full.
	assign q_take = (st_q == ST_IDLE) && q_valid &&
		!(q_word.cmd == CMD_TICK && ovalid_q && !pop);

	logic own_ok;
	logic [StepW-1:0] nx;
	logic [CntW-1:0] idx1;
	assign idx1 = CntW'(q_word.step) + 1'b1;
	assign own_ok = (idx1 < n) || (idx1 == n && repeat_mode);
	assign nx = (idx1 < n) ? StepW'(idx1) : '0;

	logic [AccW-1:0] dl [3];
	logic do_step;
	logic [CntW-1:0] nstep;
	logic [StepW-1:0] nxs;
	logic tfin;
	always_comb begin
		dl[0] = dvalid_q[step_q] ? AccW'($signed(drd[3*DeltaW-1:2*DeltaW])) : '0;
		dl[1] = dvalid_q[step_q] ? AccW'($signed(drd[2*DeltaW-1:DeltaW])) : '0;
		dl[2] = dvalid_q[step_q] ? AccW'($signed(drd[DeltaW-1:0])) : '0;
		do_step = fpos_q >= frames_q[step_q];
		nstep = CntW'(step_q) + 1'b1;
		tfin = 1'b0;
		if (nstep >= n) begin
			if (repeat_mode) begin
				nxs = '0;
			end else begin
				nxs = StepW'(n - 1'b1);
				tfin = 1'b1;
			end
		end else begin
			nxs = StepW'(nstep);
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_WAIT && ddone) begin
			unique case (ch_q)
				2'd0: dwr_q[3*DeltaW-1:2*DeltaW] <= dq;
				2'd1: dwr_q[2*DeltaW-1:DeltaW] <= dq;
				default: dwr_q[DeltaW-1:0] <= dq;
			endcase
		end
		if (st_q == ST_CALC) begin
			dwr_q <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			for (int i = 0; i < MaxSteps; i++) begin
				colour_q[i] <= '0;
				frames_q[i] <= FrameW'(1);
			end
			ramp_q <= '0;
			dvalid_q <= '0;
			run_q <= 2'd0;
			step_q <= '0;
			fpos_q <= '0;
			acc_q[0] <= '0;
			acc_q[1] <= '0;
			acc_q[2] <= '0;
			job_prev_q <= 1'b0;
			job_own_q <= 1'b0;
			from_q <= '0;
			to_q <= '0;
			widx_q <= '0;
			ch_q <= '0;
			ovalid_q <= 1'b0;
			o_lamp_q <= '0;
			o_r_q <= '0;
			o_g_q <= '0;
			o_b_q <= '0;
			o_fin_q <= 1'b0;
		end else begin
			if (pop && ovalid_q) begin
				ovalid_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (q_take) begin
						unique case (q_word.cmd)
							CMD_TICK: if (n != '0 && run_q != 2'd0) st_q <= ST_TICK;
							CMD_COLOUR: begin
								colour_q[q_word.step] <= {q_word.red, q_word.green, q_word.blue};
								job_prev_q <= (q_word.step != '0);
								job_own_q <= own_ok;
								widx_q <= q_word.step;
								to_q <= nx;
								st_q <= ST_CALC;
							end
							CMD_FRAMES: begin
								frames_q[q_word.step] <= (q_word.frames == '0) ?
									FrameW'(1) : q_word.frames;
								ramp_q[q_word.step] <= q_word.ramp;
								job_prev_q <= 1'b0;
								job_own_q <= own_ok;
								widx_q <= q_word.step;
								to_q <= nx;
								st_q <= ST_CALC;
							end
							CMD_START: begin
								step_q <= '0;
								fpos_q <= '0;
								run_q <= 2'd1;
							end
							CMD_STOP: begin
								step_q <= '0;
								fpos_q <= '0;
								run_q <= 2'd0;
							end
							CMD_PAUSE: run_q <= 2'd0;
							CMD_RESUME: run_q <= 2'd2;
							default: ;
						endcase
					end
				end
				ST_TICK: begin
					ovalid_q <= 1'b1;
					o_lamp_q <= lamp_select;
					o_fin_q <= (run_q != 2'd1) && do_step && tfin;
					st_q <= ST_IDLE;
					if (run_q == 2'd1) begin
						run_q <= 2'd2;
						acc_q[0] <= {2'b00, colour_q[step_q][23:16], 8'h00};
						acc_q[1] <= {2'b00, colour_q[step_q][15:8], 8'h00};
						acc_q[2] <= {2'b00, colour_q[step_q][7:0], 8'h00};
						o_r_q <= colour_q[step_q][23:16];
						o_g_q <= colour_q[step_q][15:8];
						o_b_q <= colour_q[step_q][7:0];
					end else begin
						fpos_q <= do_step ? FrameW'(1) : FrameW'(fpos_q + 1'b1);
						if (do_step) begin
							step_q <= nxs;
							if (tfin) run_q <= 2'd0;
							acc_q[0] <= {2'b00, colour_q[nxs][23:16], 8'h00};
							acc_q[1] <= {2'b00, colour_q[nxs][15:8], 8'h00};
							acc_q[2] <= {2'b00, colour_q[nxs][7:0], 8'h00};
							o_r_q <= colour_q[nxs][23:16];
							o_g_q <= colour_q[nxs][15:8];
							o_b_q <= colour_q[nxs][7:0];
						end else if (ramp_q[step_q]) begin
							acc_q[0] <= acc_q[0] + dl[0];
							acc_q[1] <= acc_q[1] + dl[1];
							acc_q[2] <= acc_q[2] + dl[2];
							o_r_q <= 8'((acc_q[0] + dl[0]) >> 8);
							o_g_q <= 8'((acc_q[1] + dl[1]) >> 8);
							o_b_q <= 8'((acc_q[2] + dl[2]) >> 8);
						end else begin
							o_r_q <= acc_q[0][15:8];
							o_g_q <= acc_q[1][15:8];
							o_b_q <= acc_q[2][15:8];
						end
					end
				end
				ST_CALC: begin
					ch_q <= '0;
					if (job_prev_q) begin
						job_prev_q <= 1'b0;
						from_q <= StepW'(widx_q - 1'b1);
						to_q <= widx_q;
						st_q <= ST_DIV;
					end else if (job_own_q) begin
						job_own_q <= 1'b0;
						from_q <= widx_q;
						st_q <= ST_DIV;
					end else begin
						st_q <= ST_IDLE;
					end
				end
				ST_DIV: st_q <= ST_WAIT;
				ST_WAIT: begin
					if (ddone) begin
						if (ch_q == 2'd2) begin
							st_q <= ST_RD;
						end else begin
							ch_q <= ch_q + 1'b1;
							st_q <= ST_DIV;
						end
					end
				end
				ST_RD: begin
					widx_q <= from_q;
					st_q <= ST_WR;
				end
				ST_WR: begin
					dvalid_q[from_q] <= 1'b1;
					widx_q <= to_q;
					to_q <= (CntW'(to_q) + 1'b1 < n) ? StepW'(CntW'(to_q) + 1'b1) : '0;
					st_q <= ST_CALC;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
	// The delta RAM is read at step_q as a tick leaves IDLE, so the data is ready in TICK.
endmodule

/* rtl/rkfs_checker.sv */
// Port-level checker for the fade sequencer, bound to the top level.
module rkfs_checker (
	input logic clk,
	input logic arst_n,
	input logic empty,
	input logic pop,
	input logic finished,
	input logic [7:0] red_out,
	input logic cfg_ready
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(red_out)) else $error("result changed");
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready) else $error("cfg not ready");
	a_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(finished) |-> !empty) else $error("finished without result");
	a_empty_rst: assert property (@(posedge clk)
		!arst_n |=> empty) else $error("result after reset");
endmodule

bind rgb_keyframe_fade_sequencer_core rkfs_checker u_chk (
	.clk(clk), .arst_n(arst_n), .empty(empty),
	.pop(pop), .finished(finished), .red_out(red_out), .cfg_ready(cfg_ready)
);

/* bench/tb_rgb_keyframe_fade_sequencer_core.sv */
// Self-checking testbench of the keyframe RGB fade sequencer core.
module tb_rgb_keyframe_fade_sequencer_core;
	import rkfs_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum int {PLAY_IDLE, PLAY_STARTING, PLAY_RUNNING} play_t;

	typedef struct {
		logic [7:0] lamp;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic fin;
	} colour_word_t;

	localparam int SettleCycles = 700;
	localparam int WatchdogLimit = 6000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic [2:0] cmd = 3'd0;
	logic [3:0] step_index = 4'd0;
	logic [7:0] red_in = 8'd0;
	logic [7:0] green_in = 8'd0;
	logic [7:0] blue_in = 8'd0;
	logic [14:0] frame_count = 15'd0;
	logic interpolate = 1'b0;
	logic empty;
	logic pop = 1'b0;
	logic [7:0] lamp_index;
	logic [7:0] red_out;
	logic [7:0] green_out;
	logic [7:0] blue_out;
	logic finished;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = 2'd0;
	logic [7:0] cfg_data = 8'd0;

	word_t pending_words[$];
	colour_word_t expected_colours[$];
	bit calm = 1'b0;
	bit hold = 1'b0;
	int errors = 0;
	int stall_cycles = 0;

	int steps_reg, repeat_reg, lamp_reg;
	play_t play;
	int step_pos, frame_pos;
	logic [17:0] acc[3];
	logic [7:0] colour_tab[MaxSteps][3];
	int frames_tab[MaxSteps];
	bit ramp_tab[MaxSteps];
	int delta_tab[MaxSteps][3];

	rgb_keyframe_fade_sequencer_core uut (.*);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic int steps_used();
		return steps_reg > MaxSteps ? MaxSteps : steps_reg;
	endfunction

	function automatic void ramp_delta(int from, int to);
		int diff;
		for (int c = 0; c < 3; c++) begin
			diff = (int'(colour_tab[to][c]) - int'(colour_tab[from][c])) * 256;
			delta_tab[from][c] = diff / frames_tab[from];
		end
	endfunction

	function automatic void own_delta(int idx);
		if (idx + 1 < steps_used())
			ramp_delta(idx, idx + 1);
		else if (idx + 1 == steps_used() && repeat_reg != 0)
			ramp_delta(idx, 0);
	endfunction

	function automatic void load_acc(int s);
		for (int c = 0; c < 3; c++)
			acc[c] = {2'b00, colour_tab[s][c], 8'h00};
	endfunction

	function automatic void push_colour(bit fin);
		colour_word_t r;
		r.lamp = lamp_reg[7:0];
		r.red = acc[0][15:8];
		r.green = acc[1][15:8];
		r.blue = acc[2][15:8];
		r.fin = fin;
		expected_colours.push_back(r);
	endfunction

	function automatic void sequence_word(word_t w);
		int n, nxt;
		bit fin;
		n = steps_used();
		fin = 1'b0;
		case (w.cmd)
			CMD_TICK: begin
				if (n != 0) begin
					if (play == PLAY_STARTING) begin
						play = PLAY_RUNNING;
						load_acc(step_pos);
						push_colour(1'b0);
					end else if (play == PLAY_RUNNING) begin
						if (frame_pos >= frames_tab[step_pos]) begin
							nxt = step_pos + 1;
							frame_pos = 0;
							if (nxt >= n) begin
								if (repeat_reg != 0) begin
									nxt = 0;
								end else begin
									nxt = n - 1;
									play = PLAY_IDLE;
									fin = 1'b1;
								end
							end
							step_pos = nxt & 15;
							load_acc(step_pos);
						end else if (ramp_tab[step_pos]) begin
							for (int c = 0; c < 3; c++)
								acc[c] = 18'(acc[c] + delta_tab[step_pos][c]);
						end
						push_colour(fin);
						frame_pos = (frame_pos + 1) & 16'h7FFF;
					end
				end
			end
			CMD_COLOUR: begin
				colour_tab[w.step][0] = w.red;
				colour_tab[w.step][1] = w.green;
				colour_tab[w.step][2] = w.blue;
				if (w.step > 0)
					ramp_delta(int'(w.step) - 1, int'(w.step));
				own_delta(int'(w.step));
			end
			CMD_FRAMES: begin
				frames_tab[w.step] = w.frames == 0 ? 1 : int'(w.frames);
				ramp_tab[w.step] = w.ramp;
				own_delta(int'(w.step));
			end
			CMD_START: begin
				step_pos = 0;
				frame_pos = 0;
				play = PLAY_STARTING;
			end
			CMD_STOP: begin
				step_pos = 0;
				frame_pos = 0;
				play = PLAY_IDLE;
			end
			CMD_PAUSE: play = PLAY_IDLE;
			CMD_RESUME: play = PLAY_RUNNING;
			default: ;
		endcase
	endfunction

	function automatic word_t make_word(cmd_t op, int step, int r, int g, int b,
			int frames, bit ramp);
		word_t w;
		w.cmd = op;
		w.step = step[3:0];
		w.red = r[7:0];
		w.green = g[7:0];
		w.blue = b[7:0];
		w.frames = frames[14:0];
		w.ramp = ramp;
		return w;
	endfunction

	function automatic word_t random_word();
		word_t w;
		int pick, hi;
		w = word_t'(WordW'({$urandom, $urandom}));
		hi = steps_used() > 0 ? steps_used() : 1;
		w.step = $urandom_range(0, 9) < 8 ? 4'($urandom_range(0, hi - 1)) : 4'($urandom);
		w.frames = $urandom_range(0, 9) < 8 ? 15'($urandom_range(0, 5)) : 15'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 55)
			w.cmd = CMD_TICK;
		else if (pick < 68)
			w.cmd = CMD_COLOUR;
		else if (pick < 81)
			w.cmd = CMD_FRAMES;
		else if (pick < 87)
			w.cmd = CMD_START;
		else if (pick < 90)
			w.cmd = CMD_STOP;
		else if (pick < 94)
			w.cmd = CMD_PAUSE;
		else if (pick < 98)
			w.cmd = CMD_RESUME;
		else
			w.cmd = CMD_NONE;
		return w;
	endfunction

	task automatic write_reg(reg_t idx, logic [7:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_NUM_STEPS: steps_reg = value & 8'h1F;
			REG_REPEAT: repeat_reg = value & 8'h01;
			REG_LAMP: lamp_reg = value;
			default: ;
		endcase
	endtask

	task automatic settle();
		while (pending_words.size() != 0 || push || expected_colours.size() != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	always @(posedge clk) begin : driver
		word_t cur;
		bit taken;
		if (arst_n) begin
			taken = push && !full;
			if (taken)
				sequence_word(word_t'({cmd, step_index, red_in, green_in, blue_in,
						frame_count, interpolate}));
			if (!push || taken) begin
				if (pending_words.size() != 0 && !hold &&
						(calm || $urandom_range(0, 99) >= 24)) begin
					cur = pending_words.pop_front();
					cmd <= cur.cmd;
					step_index <= cur.step;
					red_in <= cur.red;
					green_in <= cur.green;
					blue_in <= cur.blue;
					frame_count <= cur.frames;
					interpolate <= cur.ramp;
					push <= 1'b1;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endfunction

	always @(posedge clk) begin : monitor
		colour_word_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				if (expected_colours.size() == 0) begin
					errors++;
					$display("%0t: unexpected word, expected none, actual %0d %0d %0d %0d %0d",
						$time, lamp_index, red_out, green_out, blue_out, finished);
				end else begin
					want = expected_colours.pop_front();
					check_field("lamp_index", want.lamp, lamp_index);
					check_field("red_out", want.red, red_out);
					check_field("green_out", want.green, green_out);
					check_field("blue_out", want.blue, blue_out);
					check_field("finished", want.fin, finished);
				end
			end
			pop <= calm || $urandom_range(0, 99) >= 24;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WatchdogLimit) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		steps_reg = 0;
		repeat_reg = 0;
		lamp_reg = 0;
		play = PLAY_IDLE;
		step_pos = 0;
		frame_pos = 0;
		for (int c = 0; c < 3; c++)
			acc[c] = '0;
		for (int i = 0; i < MaxSteps; i++) begin
			frames_tab[i] = 1;
			ramp_tab[i] = 1'b0;
			for (int c = 0; c < 3; c++) begin
				colour_tab[i][c] = 8'd0;
				delta_tab[i][c] = 0;
			end
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		write_reg(REG_NUM_STEPS, 8'd3);
		write_reg(REG_REPEAT, 8'd0);
		write_reg(REG_LAMP, 8'hA5);
		pending_words.push_back(make_word(CMD_TICK, 0, 0, 0, 0, 0, 0));
		pending_words.push_back(make_word(CMD_COLOUR, 0, 255, 0, 255, 0, 0));
		pending_words.push_back(make_word(CMD_COLOUR, 1, 0, 255, 0, 0, 0));
		pending_words.push_back(make_word(CMD_COLOUR, 2, 255, 255, 255, 0, 0));
		pending_words.push_back(make_word(CMD_FRAMES, 0, 0, 0, 0, 0, 1));
		pending_words.push_back(make_word(CMD_FRAMES, 1, 0, 0, 0, 3, 1));
		pending_words.push_back(make_word(CMD_FRAMES, 2, 0, 0, 0, 2, 0));
		pending_words.push_back(make_word(CMD_COLOUR, 15, 17, 34, 51, 0, 0));
		pending_words.push_back(make_word(CMD_START, 0, 0, 0, 0, 0, 0));
		repeat (9) pending_words.push_back(make_word(CMD_TICK, 0, 0, 0, 0, 0, 0));
		pending_words.push_back(make_word(CMD_START, 0, 0, 0, 0, 0, 0));
		repeat (2) pending_words.push_back(make_word(CMD_TICK, 0, 0, 0, 0, 0, 0));
		pending_words.push_back(make_word(CMD_PAUSE, 0, 0, 0, 0, 0, 0));
		pending_words.push_back(make_word(CMD_TICK, 0, 0, 0, 0, 0, 0));
		pending_words.push_back(make_word(CMD_RESUME, 0, 0, 0, 0, 0, 0));
		pending_words.push_back(make_word(CMD_TICK, 0, 0, 0, 0, 0, 0));
		pending_words.push_back(make_word(CMD_FRAMES, 1, 0, 0, 0, 1, 1));
		repeat (2) pending_words.push_back(make_word(CMD_TICK, 0, 0, 0, 0, 0, 0));
		pending_words.push_back(make_word(CMD_STOP, 0, 0, 0, 0, 0, 0));
		pending_words.push_back(make_word(CMD_NONE, 0, 0, 0, 0, 0, 0));
		pending_words.push_back(make_word(CMD_TICK, 0, 0, 0, 0, 0, 0));
		pending_words.push_back(make_word(CMD_FRAMES, 3, 0, 0, 0, 32767, 1));
		settle();

		for (int p = 0; p < 9; p++) begin
			write_reg(REG_NUM_STEPS, p == 0 ? 8'd16 : p == 1 ? 8'd0 : p == 2 ? 8'hFF :
				8'($urandom_range(1, 16)));
			write_reg(REG_REPEAT, 8'(p % 2 == 0 ? 1 : $urandom_range(0, 1)));
			write_reg(REG_LAMP, p == 0 ? 8'hFF : p == 1 ? 8'h00 : 8'($urandom));
			calm = (p == 3);
			pending_words.push_back(make_word(CMD_START, 0, 0, 0, 0, 0, 0));
			repeat (45) pending_words.push_back(random_word());
			if (p == 4) begin
				while (pending_words.size() > 25)
					@(posedge clk);
				hold = 1'b1;
				while (push || expected_colours.size() != 0)
					@(posedge clk);
				hold = 1'b0;
			end
			settle();
		end

		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
